>>> design/gwm_pkg.sv
// Shared constants and types of the glob wildcard matcher.
// No dependencies; every other file imports this package.
`default_nettype none

package gwm_pkg;

  localparam int unsigned GWM_MAX_PATTERN = 32;
  localparam int unsigned GWM_CHAR_BITS   = 16;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CH_W   = 16;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUBJ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_END    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

  // Wildcard character codes
  localparam logic [CH_W-1:0] STAR_CODE  = 16'h002A;
  localparam logic [CH_W-1:0] QMARK_CODE = 16'h003F;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic restart;  // reseed position 0 and rebuild the star closure
    logic step;     // advance by one subject character
    logic clear;    // drop the whole pattern
  } gwm_ctrl_t;

endpackage

`default_nettype wire

>>> design/gwm_if.sv
// Valid/ready channel interfaces for the matcher's input and result words.
// Depends on gwm_pkg.
`default_nettype none

interface gwm_in_if import gwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CH_W-1:0]   ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink   (input valid, input func, input ch, output ready);
endinterface

interface gwm_out_if import gwm_pkg::*; ();
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

>>> design/gwm_cell.sv
// One pattern position: stored character, valid bit and active bit.
// Depends on gwm_pkg.
`default_nettype none

module gwm_cell import gwm_pkg::*; #(
  parameter int unsigned CHAR_BITS = GWM_CHAR_BITS,
  parameter logic        RST_ACT   = 1'b0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gwm_ctrl_t            ctrl_i,
  input  wire logic                 load_i,
  input  wire logic [CHAR_BITS-1:0] ch_i,
  input  wire logic                 adv_i,   // advance hit from left neighbor
  input  wire logic                 clos_i,  // star closure from left neighbor
  output logic                      adv_o,
  output logic                      clos_o,
  output logic                      act_o
);

  logic [CHAR_BITS-1:0] char_q, char_d;
  logic                 valid_q, valid_d;
  logic                 act_q, act_d;
  logic                 is_star, is_qmark, hold, raw;

  // Work on the pattern as it will be after this word, so a restart
  // following an append sees the new character.
  always_comb begin
    char_d  = load_i ? ch_i : char_q;
    valid_d = ctrl_i.clear ? 1'b0 : (load_i ? 1'b1 : valid_q);
  end

  always_comb begin
    is_star  = valid_d && (char_d == STAR_CODE[CHAR_BITS-1:0]);
    is_qmark = (char_d == QMARK_CODE[CHAR_BITS-1:0]);
    hold     = !ctrl_i.restart && act_q && valid_d;
    raw      = adv_i || (hold && is_star);
    act_d    = raw || (clos_i && is_star) ? 1'b1 : (raw || clos_i);
    clos_o   = act_d && is_star;
    adv_o    = hold && !is_star && (is_qmark || (char_d == ch_i));
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      char_q <= ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= RST_ACT;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.restart || ctrl_i.step) begin
        act_q <= act_d;
      end
    end
  end

  assign act_o = act_q;

endmodule

`default_nettype wire

>>> design/glob_wildcard_matcher_core.sv
// Top level of the glob wildcard matcher: control decode, cell chain, result register.
// Depends on gwm_pkg, gwm_if and gwm_cell.
`default_nettype none

//  channel | dir | modport | payload                    | word accepted when
//  in_i    | in  | sink    | func[1:0], ch[15:0]        | in_i.valid && in_i.ready
//  out_o   | out | source  | matched, pattern_overflow  | out_o.valid && out_o.ready
//
//  A new word is taken each cycle, except while input stalls as described below.
//  The active-position set advances through the chain of MAX_PATTERN cells by
//  one position step per subject character; star closure ripples cell to cell.
//  Only an end word makes a result, held in a one-deep output register;
//  input stalls only while that register is full and not being drained.
//  Async reset empties the pattern, clears the overflow flag and leaves
//  position 0 active. Stored characters are not reset.

module glob_wildcard_matcher_core import gwm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = GWM_MAX_PATTERN,
  parameter int unsigned CHAR_BITS   = GWM_CHAR_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gwm_in_if.sink     in_i,
  gwm_out_if.source  out_o
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  logic                   accept;
  gwm_ctrl_t              ctrl;
  logic [CHAR_BITS-1:0]   ch_m;
  logic                   acc_append, acc_end, len_full;

  logic [LEN_W-1:0]       len_q, len_d;
  logic                   ovf_q, ovf_d;
  logic                   tail_q;

  // Chain links: index i feeds cell i, index i+1 leaves it.
  logic [MAX_PATTERN:0]   adv;
  logic [MAX_PATTERN:0]   clos;
  logic [MAX_PATTERN:0]   act_vec;  // active positions, MAX_PATTERN is the tail

  logic                   out_valid_q, matched_q, out_ovf_q;

  // ------------------------------------------------------------------
  // Handshake and decode
  // ------------------------------------------------------------------
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign ch_m       = in_i.ch[CHAR_BITS-1:0];

  assign acc_append = accept && (in_i.func == FUNC_APPEND);
  assign acc_end    = accept && (in_i.func == FUNC_END);
  assign len_full   = (len_q == LEN_W'(MAX_PATTERN));

  // Anything but a subject character restarts matching from position 0.
  always_comb begin
    ctrl.restart = accept && (in_i.func != FUNC_SUBJ);
    ctrl.step    = accept && (in_i.func == FUNC_SUBJ);
    ctrl.clear   = accept && (in_i.func == FUNC_CLEAR);
  end

  // ------------------------------------------------------------------
  // Pattern length and overflow flag
  // ------------------------------------------------------------------
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (ctrl.clear) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else if (acc_append) begin
      if (len_full) begin
        ovf_d = 1'b1;  // pattern full: character dropped
      end else begin
        len_d = len_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  // ------------------------------------------------------------------
  // Cell chain. On restart the seed enters cell 0 through its advance
  // input and spreads across leading stars.
  // ------------------------------------------------------------------
  assign adv[0]  = ctrl.restart;
  assign clos[0] = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    gwm_cell #(
      .CHAR_BITS (CHAR_BITS),
      .RST_ACT   (i == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .load_i (acc_append && (len_q == LEN_W'(i))),
      .ch_i   (ch_m),
      .adv_i  (adv[i]),
      .clos_i (clos[i]),
      .adv_o  (adv[i+1]),
      .clos_o (clos[i+1]),
      .act_o  (act_vec[i])
    );
  end

  // Position past the last cell: reached only with a full pattern.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= 1'b0;
    end else if (ctrl.restart || ctrl.step) begin
      tail_q <= adv[MAX_PATTERN] || clos[MAX_PATTERN];
    end
  end

  assign act_vec[MAX_PATTERN] = tail_q;

  // ------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc_end) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_end) begin
      matched_q <= act_vec[len_q];
      out_ovf_q <= ovf_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = out_ovf_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`ifndef SYNTH
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (len_q == '0) && !ovf_q)
    else $error("clear did not empty the pattern");

  a_restart_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.restart |=> act_vec[0])
    else $error("position 0 not active after restart");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(acc_end))
    else $error("result word without an end word");
`endif

endmodule

`default_nettype wire

>>> verif/gwm_verdict_checker.sv
// Checker for the glob wildcard matcher: watches both channels, predicts verdicts, compares.
// Depends on gwm_pkg and gwm_if; instantiated by tb beside the block.
`default_nettype none

module gwm_verdict_checker import gwm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gwm_in_if           in_mon,
  gwm_out_if          out_mon,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAXP = GWM_MAX_PATTERN;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // predictor state
  logic [CH_W-1:0] pat_chars [MAXP];
  logic [5:0]      pat_len  = '0;
  logic [MAXP:0]   live_pos = (MAXP+1)'(1);
  logic            ovf      = 1'b0;

  verdict_t    verdict_q [$];
  int unsigned fail_cnt = 0;

  // a '*' may match an empty run, so its successor is live too
  function automatic logic [MAXP:0] close_stars(logic [MAXP:0] pos);
    for (int i = 0; i < MAXP; i++) begin
      if (i < pat_len && pos[i] && pat_chars[i] == STAR_CODE) pos[i+1] = 1'b1;
    end
    return pos;
  endfunction

  function automatic logic [MAXP:0] seed_positions();
    return close_stars({{MAXP{1'b0}}, 1'b1});
  endfunction

  function automatic logic [MAXP:0] advance_positions(logic [CH_W-1:0] c);
    logic [MAXP:0] nxt;
    nxt = '0;
    for (int i = 0; i < MAXP; i++) begin
      if (i < pat_len && live_pos[i]) begin
        if (pat_chars[i] == STAR_CODE) nxt[i] = 1'b1;
        else if (pat_chars[i] == QMARK_CODE || pat_chars[i] == c) nxt[i+1] = 1'b1;
      end
    end
    return close_stars(nxt);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got;
    verdict_t want;
    if (!rst_ni) begin
      pat_len  = '0;
      ovf      = 1'b0;
      live_pos = seed_positions();
      verdict_q.delete();
    end else begin
      // result side first: a word leaving now was predicted at an earlier edge
      if (out_mon.valid && out_mon.ready) begin
        got.matched  = out_mon.matched;
        got.overflow = out_mon.pattern_overflow;
        if (verdict_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result word, expected none, actual matched=%b ovf=%b",
                   $time, got.matched, got.overflow);
        end else begin
          want = verdict_q.pop_front();
          if (got.matched !== want.matched) begin
            fail_cnt++;
            $display("%0t: matched mismatch, expected %b actual %b",
                     $time, want.matched, got.matched);
          end
          if (got.overflow !== want.overflow) begin
            fail_cnt++;
            $display("%0t: pattern_overflow mismatch, expected %b actual %b",
                     $time, want.overflow, got.overflow);
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.func)
          FUNC_APPEND: begin
            if (pat_len < MAXP) begin
              pat_chars[pat_len] = in_mon.ch;
              pat_len = pat_len + 6'd1;
            end else begin
              ovf = 1'b1;
            end
            live_pos = seed_positions();
          end
          FUNC_SUBJ: begin
            live_pos = advance_positions(in_mon.ch);
          end
          FUNC_END: begin
            want.matched  = live_pos[pat_len];
            want.overflow = ovf;
            verdict_q.push_back(want);
            live_pos = seed_positions();
          end
          FUNC_CLEAR: begin
            pat_len  = '0;
            ovf      = 1'b0;
            live_pos = seed_positions();
          end
          default: ;
        endcase
      end
    end
    errors_o  <= fail_cnt;
    pending_o <= verdict_q.size();
  end

endmodule

`default_nettype wire

>>> verif/tb.sv
// Testbench top for glob_wildcard_matcher_core: clock, reset, stimulus and verdict.
// Depends on gwm_pkg, gwm_if, the core and gwm_verdict_checker.
`default_nettype none

module tb import gwm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 1400;
  localparam int unsigned CALM_AFTER   = 1200;  // no idling on either side past this
  localparam int unsigned DRAIN_AT     = 700;   // sender waits for all verdicts once here
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam logic [CH_W-1:0] CH_A = 16'h0061;
  localparam logic [CH_W-1:0] CH_B = 16'h0062;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gwm_in_if  in_ch ();
  gwm_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent    = 0;
  int unsigned cycles  = 0;
  bit          calm    = 1'b0;
  bit          drained = 1'b0;
  int          hold_left;

  glob_wildcard_matcher_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  gwm_verdict_checker u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors_o  (fail_count),
    .pending_o (pending)
  );

  always #4 clk_i = ~clk_i;

  // watchdog: a hang or a lost verdict ends here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts, none in the calm tail.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Push one word; may first drop valid for a random burst.
  // Valid stays high across back-to-back words, so each step has one assignment to it.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CH_W-1:0] c);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.ch    <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // Sender goes quiet until the checker holds no outstanding verdict.
  task automatic drain_verdicts();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // pattern alphabet: stars and '?' are common so closures get exercised
  function automatic logic [CH_W-1:0] pick_pattern_char();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return STAR_CODE;
      3, 4:    return QMARK_CODE;
      9:       return CH_W'($urandom_range(0, 65535));
      default: return r[0] ? CH_A : CH_B;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_letter();
    int r;
    r = $urandom_range(0, 7);
    if (r == 7) return CH_W'($urandom_range(0, 65535));
    return r[0] ? CH_A : CH_B;
  endfunction

  initial begin
    int plen;
    int nsub;
    int n;
    int idx;
    bit first_seq;
    logic [CH_W-1:0] pat_q [$];
    logic [CH_W-1:0] subj_q [$];

    in_ch.valid = 1'b0;
    in_ch.func  = FUNC_CLEAR;
    in_ch.ch    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ---- directed part ----
    // empty pattern, empty subject: match
    send_word(FUNC_CLEAR, '0);
    send_word(FUNC_END, '0);
    // pattern of a lone star: empty subject and any subject match,
    // code zero counts as an ordinary character
    send_word(FUNC_APPEND, STAR_CODE);
    send_word(FUNC_END, '0);
    send_word(FUNC_SUBJ, 16'h0000);
    send_word(FUNC_SUBJ, 16'hFFFF);
    send_word(FUNC_END, '0);
    // literal extremes and '?' in the middle
    send_word(FUNC_CLEAR, '0);
    send_word(FUNC_APPEND, 16'h0001);
    send_word(FUNC_APPEND, QMARK_CODE);
    send_word(FUNC_APPEND, 16'hFFFF);
    send_word(FUNC_SUBJ, 16'h0001);
    send_word(FUNC_SUBJ, 16'h0000);
    send_word(FUNC_SUBJ, 16'hFFFF);
    send_word(FUNC_END, '0);
    // append in the middle of a subject abandons it: verdict is for an empty subject
    send_word(FUNC_SUBJ, 16'h0001);
    send_word(FUNC_APPEND, STAR_CODE);
    send_word(FUNC_END, '0);
    // trailing star swallows the tail; alternating bit patterns on ch
    send_word(FUNC_SUBJ, 16'h0001);
    send_word(FUNC_SUBJ, 16'hAAAA);
    send_word(FUNC_SUBJ, 16'hFFFF);
    send_word(FUNC_SUBJ, 16'h5555);
    send_word(FUNC_END, '0);
    send_word(FUNC_END, '0);
    send_word(FUNC_CLEAR, '0);

    // ---- random part ----
    // Mostly well-formed: load a pattern, then subjects built from it so many match.
    // The first sequence overfills the pattern store; later ones do so now and then.
    first_seq = 1'b1;
    while (sent < RANDOM_WORDS + 25) begin
      if (!drained && sent >= DRAIN_AT) begin
        drain_verdicts();
        drained = 1'b1;
      end
      if (sent >= CALM_AFTER + 25) calm = 1'b1;

      if (!first_seq && $urandom_range(0, 9) == 0) begin
        // noise: arbitrary functions and codes
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_word(FUNC_W'($urandom_range(0, 3)), CH_W'($urandom_range(0, 65535)));
        end
      end else begin
        if (first_seq || $urandom_range(0, 3) != 0) begin
          send_word(FUNC_CLEAR, CH_W'($urandom_range(0, 65535)));
          pat_q.delete();
        end
        if (first_seq) plen = 34;
        else if ($urandom_range(0, 19) == 0) plen = $urandom_range(30, 36);
        else plen = $urandom_range(0, 5);
        first_seq = 1'b0;
        repeat (plen) begin
          pat_q.push_back(pick_pattern_char());
          send_word(FUNC_APPEND, pat_q[pat_q.size()-1]);
        end
        // only what the store kept shapes the subjects
        while (pat_q.size() > GWM_MAX_PATTERN) void'(pat_q.pop_back());

        nsub = $urandom_range(1, 4);
        repeat (nsub) begin
          subj_q.delete();
          foreach (pat_q[i]) begin
            if (pat_q[i] == STAR_CODE) begin
              n = $urandom_range(0, 3);
              repeat (n) subj_q.push_back(pick_letter());
            end else if (pat_q[i] == QMARK_CODE) begin
              subj_q.push_back(pick_letter());
            end else begin
              subj_q.push_back(pat_q[i]);
            end
          end
          // break about a quarter of the subjects: swap, drop or add a character
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
              0: if (subj_q.size() > 0) begin
                idx = $urandom_range(0, subj_q.size() - 1);
                subj_q[idx] = pick_letter();
              end
              1: if (subj_q.size() > 0) begin
                idx = $urandom_range(0, subj_q.size() - 1);
                subj_q.delete(idx);
              end
              default: subj_q.push_back(pick_letter());
            endcase
          end
          foreach (subj_q[i]) begin
            // rare disruption in mid-subject: a stray clear or append
            if ($urandom_range(0, 40) == 0) begin
              send_word($urandom_range(0, 1) ? FUNC_CLEAR : FUNC_APPEND, pick_letter());
            end
            send_word(FUNC_SUBJ, subj_q[i]);
          end
          send_word(FUNC_END, CH_W'($urandom_range(0, 65535)));
        end
      end
    end

    // wait out every verdict, then keep watching for anything unexpected
    drain_verdicts();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
